// File: src/cdss_pkg.sv
// ----------------------------------------------------------------------------
// cdss_pkg
// Constants, types and the lag table of the sync-skipping deinterleaver.
// ----------------------------------------------------------------------------
package cdss_pkg;

    localparam int unsigned BRANCHES     = 36;
    localparam int unsigned BRANCH_DELAY = 64;
    localparam int unsigned FRAME_DATA   = 80;
    localparam int unsigned RING_DEPTH   = 82944;
    localparam int unsigned SYNC_LEN     = 8;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned ADDR_W  = $clog2(RING_DEPTH);
    localparam int unsigned PHASE_W = $clog2(FRAME_DATA + 1);
    localparam int unsigned SKIP_W  = 4;

    localparam int unsigned LEAD = (BRANCHES * BRANCH_DELAY) % RING_DEPTH;

    typedef logic [DATA_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef t_addr t_lag_table [FRAME_DATA];

    function automatic t_lag_table f_build_lag();
        t_lag_table tbl;
        longint     branch;
        longint     offset;
        for (int i = 0; i < int'(FRAME_DATA); i++) begin
            branch = longint'(i);
            while (branch >= longint'(BRANCHES)) begin
                branch -= longint'(BRANCHES);
            end
            offset = branch * longint'(BRANCHES) * longint'(BRANCH_DELAY);
            while (offset >= longint'(RING_DEPTH)) begin
                offset -= longint'(RING_DEPTH);
            end
            tbl[i] = ADDR_W'(offset);
        end
        return tbl;
    endfunction

    localparam t_lag_table LAG_TABLE = f_build_lag();

endpackage

// File: src/cdss_if.sv
// ----------------------------------------------------------------------------
// cdss_if
// Valid/ready channels carrying the input and output bytes.
// ----------------------------------------------------------------------------
interface cdss_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface cdss_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// File: src/convolutional_deinterleaver_sync_skip.sv
// ----------------------------------------------------------------------------
// convolutional_deinterleaver_sync_skip
// Convolutional deinterleaver that drops the sync bytes opening each frame.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle unless stage register and output
// queue hold three bytes; each data byte passes through the stage register
// and queue, and sync bytes at the start of a frame give no output. The ring
// memory sees one write and one read per data byte. After reset the ring is
// cleared one entry per cycle and no request is accepted until that pass
// ends. A two-entry output queue lets input flow on while a result waits.
module convolutional_deinterleaver_sync_skip (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdss_in_if.sink    i_in,
    cdss_out_if.source o_out
);
    import cdss_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W + 1)'(RING_DEPTH);
    localparam logic [ADDR_W:0] LEAD_X  = (ADDR_W + 1)'(LEAD);

    t_state               r_state;
    t_addr                r_clr_addr;
    t_addr                r_wp;
    logic [PHASE_W-1:0]   r_phase;
    logic [SKIP_W-1:0]    r_skip;
    t_byte                r_ring [RING_DEPTH];
    t_byte                r_rd_data;
    logic                 r_s1_valid;
    logic                 r_s1_hit;
    t_byte                r_s1_byte;
    t_byte                r_q [2];
    logic                 r_q_wr;
    logic                 r_q_rd;
    logic [1:0]           r_q_cnt;

    logic                 n_s1_valid;
    logic [1:0]           n_q_cnt;
    logic                 accept;
    logic                 drop;
    logic                 take;
    t_addr                lag;
    t_addr                waddr;
    t_addr                raddr;
    logic [ADDR_W:0]      rsum;
    logic [ADDR_W:0]      wsum;
    logic                 mem_we;
    t_addr                mem_waddr;
    t_byte                mem_wdata;
    t_byte                s1_data;
    logic                 push;
    logic                 pop;
    logic [1:0]           occupancy;

    assign occupancy = {1'b0, r_s1_valid} + r_q_cnt;
    assign i_in.ready = (r_state == ST_RUN) && (occupancy != 2'd3);
    assign accept = i_in.valid && i_in.ready;
    assign drop = (r_phase == '0) && (r_skip < SKIP_W'(SYNC_LEN));
    assign take = accept && !drop;

    assign lag  = LAG_TABLE[r_phase];
    assign rsum = {1'b0, r_wp} + LEAD_X;
    assign wsum = {1'b0, r_wp} + DEPTH_X - {1'b0, lag};

    always_comb begin
        if (rsum >= DEPTH_X) begin
            raddr = ADDR_W'(rsum - DEPTH_X);
        end else begin
            raddr = ADDR_W'(rsum);
        end
        if (r_wp >= lag) begin
            waddr = r_wp - lag;
        end else begin
            waddr = ADDR_W'(wsum);
        end
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = take;
            mem_waddr = waddr;
            mem_wdata = t_byte'(i_in.in_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_waddr] <= mem_wdata;
        end
        if (take) begin
            r_rd_data <= r_ring[raddr];
            r_s1_hit  <= (waddr == raddr);
            r_s1_byte <= t_byte'(i_in.in_byte);
        end
    end

    assign s1_data = r_s1_hit ? r_s1_byte : r_rd_data;
    assign push = r_s1_valid && (r_q_cnt != 2'd2);
    assign pop  = (r_q_cnt != 2'd0) && o_out.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (take) begin
            n_s1_valid = 1'b1;
        end else if (push) begin
            n_s1_valid = 1'b0;
        end
        n_q_cnt = r_q_cnt;
        case ({push, pop})
            2'b10:   n_q_cnt = r_q_cnt + 2'd1;
            2'b01:   n_q_cnt = r_q_cnt - 2'd1;
            default: n_q_cnt = r_q_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_q_wr] <= s1_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_wp       <= '0;
            r_phase    <= '0;
            r_skip     <= '0;
            r_s1_valid <= 1'b0;
            r_q_wr     <= 1'b0;
            r_q_rd     <= 1'b0;
            r_q_cnt    <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (r_clr_addr == ADDR_W'(RING_DEPTH - 1)) begin
                        r_state <= ST_RUN;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_RUN;
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
            if (accept) begin
                if (drop) begin
                    r_skip <= r_skip + 1'b1;
                end else begin
                    r_skip <= '0;
                    if (r_wp == ADDR_W'(RING_DEPTH - 1)) begin
                        r_wp <= '0;
                    end else begin
                        r_wp <= r_wp + 1'b1;
                    end
                    if (r_phase == PHASE_W'(FRAME_DATA - 1)) begin
                        r_phase <= '0;
                    end else begin
                        r_phase <= r_phase + 1'b1;
                    end
                end
            end
            r_s1_valid <= n_s1_valid;
            r_q_cnt    <= n_q_cnt;
            if (push) begin
                r_q_wr <= ~r_q_wr;
            end
            if (pop) begin
                r_q_rd <= ~r_q_rd;
            end
        end
    end

    assign o_out.valid    = (r_q_cnt != 2'd0);
    assign o_out.out_byte = signed'(r_q[r_q_rd]);

endmodule

// File: src/cdss_checker.sv
// ----------------------------------------------------------------------------
// cdss_checker
// Port-level checks on the sync-skipping deinterleaver, bound to the top level.
// ----------------------------------------------------------------------------
module cdss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte
);

    // The ring is cleared after reset, so no request is taken and nothing
    // is shown in the cycle that follows it.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_in_ready && !i_out_valid))
        else $error("request accepted or result shown straight after reset");

    // A result that appears from an empty output comes from an accepted request
    // that went through the stage register and then into the output queue.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a matching request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte)))
        else $error("stalled result changed or was withdrawn");

endmodule

bind convolutional_deinterleaver_sync_skip cdss_checker u_cdss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte)
);
